FILE: src/c2la_pkg.sv
// shared types, constants and elaboration-time tables of the look-angle converter
package c2la_pkg;

  localparam int DATA_W       = 64;
  localparam int Z_W          = 42;
  localparam int CORDIC_ITERS = 40;
  localparam int NORM_STAGES  = 3;
  localparam int ATAN_LAT     = NORM_STAGES + CORDIC_ITERS;
  localparam int SQRT_STEPS   = 32;
  localparam int NORM_MSB     = 59;

  typedef logic signed [DATA_W-1:0] word_t;
  typedef logic signed [Z_W-1:0]    ang_t;

  localparam logic [63:0] PI_Q56 = 64'h0324_3F6A_8885_A308;

  localparam ang_t DEG45  = ang_t'(64'd45 << 32);
  localparam ang_t DEG90  = ang_t'(64'd90 << 32);
  localparam ang_t DEG180 = ang_t'(64'd180 << 32);

  // restoring long division, only evaluated at elaboration
  function automatic logic [127:0] udiv(input logic [127:0] num, input logic [63:0] den);
    logic [127:0] q;
    logic [64:0]  rem;
    q   = '0;
    rem = '0;
    for (int b = 127; b >= 0; b--) begin
      rem = {rem[63:0], num[b]};
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[b] = 1'b1;
      end
    end
    return q;
  endfunction

  // atan(2^-i) in degrees, 32 fractional bits, truncated
  function automatic ang_t atan_q32(input int i);
    logic [63:0]  rad;
    logic [63:0]  term;
    logic [63:0]  n;
    logic [127:0] q;
    int           e;
    rad = '0;
    for (int k = 0; k < 64; k++) begin
      e = 56 - i * (2 * k + 1);
      if (e >= 0) begin
        term = 64'(udiv(128'd1 << e, 64'(2 * k + 1)));
        if (k[0]) rad = rad - term;
        else rad = rad + term;
      end
    end
    n = rad * 64'd180;
    q = udiv({32'd0, n, 32'd0}, PI_Q56);
    return (i == 0) ? DEG45 : ang_t'(q);
  endfunction

  // position of the highest set bit, zero for a zero word
  function automatic logic [5:0] msb_index(input logic [63:0] v);
    logic [5:0] p;
    p = '0;
    for (int k = 0; k < 64; k++) begin
      if (v[k]) p = 6'(k);
    end
    return p;
  endfunction

endpackage

FILE: src/c2la_atan2.sv
// pipelined vectoring cordic atan2 in degrees with 32 fractional bits
module c2la_atan2 (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  c2la_pkg::word_t y,
  input  c2la_pkg::word_t x,
  output logic          out_valid,
  output c2la_pkg::ang_t  z
);
  import c2la_pkg::*;

  // stage a: magnitudes and special cases
  logic        a_vld;
  logic [63:0] a_my, a_mx, a_m;
  logic        a_ny, a_nx, a_spec;
  ang_t        a_sz;

  always_ff @(posedge clk) begin
    if (rst) a_vld <= 1'b0;
    else a_vld <= in_valid;
    a_my <= y[63] ? 64'(-y) : 64'(y);
    a_mx <= x[63] ? 64'(-x) : 64'(x);
    a_m  <= ((y[63] ? 64'(-y) : 64'(y)) > (x[63] ? 64'(-x) : 64'(x))) ?
            (y[63] ? 64'(-y) : 64'(y)) : (x[63] ? 64'(-x) : 64'(x));
    a_ny <= y[63];
    a_nx <= x[63];
    a_spec <= (y == '0) || (x == '0);
    if (y == '0) a_sz <= x[63] ? DEG180 : '0;
    else a_sz <= y[63] ? -DEG90 : DEG90;
  end

  // stage b: leading one search
  logic        b_vld;
  logic [63:0] b_my, b_mx;
  logic        b_ny, b_nx, b_spec;
  ang_t        b_sz;
  logic [5:0]  b_p;

  always_ff @(posedge clk) begin
    if (rst) b_vld <= 1'b0;
    else b_vld <= a_vld;
    b_my <= a_my;
    b_mx <= a_mx;
    b_ny <= a_ny;
    b_nx <= a_nx;
    b_spec <= a_spec;
    b_sz <= a_sz;
    b_p  <= msb_index(a_m);
  end

  // stage c: normalize and pre-rotate into the right half plane
  logic [63:0] mys, mxs;
  word_t       sy, sx;

  always_comb begin
    if (b_p > 6'(NORM_MSB)) begin
      mys = b_my >> (b_p - 6'(NORM_MSB));
      mxs = b_mx >> (b_p - 6'(NORM_MSB));
    end else begin
      mys = b_my << (6'(NORM_MSB) - b_p);
      mxs = b_mx << (6'(NORM_MSB) - b_p);
    end
    sy = b_ny ? -word_t'(mys) : word_t'(mys);
    sx = b_nx ? -word_t'(mxs) : word_t'(mxs);
  end

  word_t it_x   [CORDIC_ITERS+1];
  word_t it_y   [CORDIC_ITERS+1];
  ang_t  it_z   [CORDIC_ITERS+1];
  ang_t  it_sz  [CORDIC_ITERS+1];
  logic  it_spec[CORDIC_ITERS+1];
  logic  it_vld [CORDIC_ITERS+1];

  always_ff @(posedge clk) begin
    if (rst) it_vld[0] <= 1'b0;
    else it_vld[0] <= b_vld;
    it_spec[0] <= b_spec;
    it_sz[0]   <= b_sz;
    if (sx[63]) begin
      if (!sy[63]) begin
        it_x[0] <= sy;
        it_y[0] <= -sx;
        it_z[0] <= DEG90;
      end else begin
        it_x[0] <= -sy;
        it_y[0] <= sx;
        it_z[0] <= -DEG90;
      end
    end else begin
      it_x[0] <= sx;
      it_y[0] <= sy;
      it_z[0] <= '0;
    end
  end

  // one micro-rotation per stage
  for (genvar i = 0; i < CORDIC_ITERS; i++) begin : g_iter
    localparam ang_t ATAN_I = atan_q32(i);
    always_ff @(posedge clk) begin
      if (rst) it_vld[i+1] <= 1'b0;
      else it_vld[i+1] <= it_vld[i];
      it_spec[i+1] <= it_spec[i];
      it_sz[i+1]   <= it_sz[i];
      if (!it_y[i][63]) begin
        it_x[i+1] <= it_x[i] + (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] - (it_x[i] >>> i);
        it_z[i+1] <= it_z[i] + ATAN_I;
      end else begin
        it_x[i+1] <= it_x[i] - (it_y[i] >>> i);
        it_y[i+1] <= it_y[i] + (it_x[i] >>> i);
        it_z[i+1] <= it_z[i] - ATAN_I;
      end
    end
  end

  assign out_valid = it_vld[CORDIC_ITERS];
  assign z = it_spec[CORDIC_ITERS] ? it_sz[CORDIC_ITERS] : it_z[CORDIC_ITERS];

endmodule

FILE: src/cartesian_to_look_angles_unit.sv
// top level: enu position to azimuth, elevation and slant range
//
// usage
//   - an item (east_pos, north_pos, up_pos) is taken at each rising edge with
//     start high and busy low; busy is always low, so an item can enter
//     every cycle
//   - each result appears on azimuth_angle, elevation_angle and slant_range
//     for exactly one cycle with done high, in input order
//   - an item passes through 82 register stages: input register,
//     squares, sums, scaling, 32-step square root of the horizontal range,
//     then the 43-stage cordic for the elevation and two rounding stages;
//     azimuth and slant range are delayed to line up with it
//   - throughput is one item per cycle, set by the fully pipelined cordic
//     and square root stages
//   - synchronous reset clears every valid bit, so no done pulse follows
//     reset until a new item comes in; data registers are not reset
//   - the receiver cannot stall, so nothing ever holds back the pipeline
//   - angles are degrees with ANGLE_FRAC_BITS fraction bits, rounded half
//     away from zero; slant range is the floor of the euclidean norm
module cartesian_to_look_angles_unit #(
  parameter int COORD_WIDTH     = 32,
  parameter int ANGLE_FRAC_BITS = 10
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic signed [COORD_WIDTH-1:0]   east_pos,
  input  logic signed [COORD_WIDTH-1:0]   north_pos,
  input  logic signed [COORD_WIDTH-1:0]   up_pos,
  output logic                            done,
  output logic signed [ANGLE_FRAC_BITS+8:0] azimuth_angle,
  output logic signed [ANGLE_FRAC_BITS+7:0] elevation_angle,
  output logic [31:0]                     slant_range
);
  import c2la_pkg::*;

  localparam int CW_USED = (COORD_WIDTH < 32) ? COORD_WIDTH : 32;
  localparam int AZ_W    = ANGLE_FRAC_BITS + 9;
  localparam int EL_W    = ANGLE_FRAC_BITS + 8;
  localparam int RND_SH  = 32 - ANGLE_FRAC_BITS;
  localparam logic [Z_W-1:0] RND_HALF = Z_W'(1) << (RND_SH - 1);

  // stage numbers: an item sits in stage k when vld[k] is set
  localparam int SCL_ST = 5;
  localparam int TOT_ST = 4;
  localparam int H_ST   = SCL_ST + SQRT_STEPS;
  localparam int SR_ST  = TOT_ST + SQRT_STEPS;
  localparam int AZ_Z   = 1 + ATAN_LAT;
  localparam int EL_Z   = H_ST + ATAN_LAT;
  localparam int AZ_RND = AZ_Z + 2;
  localparam int LAST   = EL_Z + 2;
  localparam int AZ_DLY = LAST - AZ_RND;
  localparam int SR_DLY = LAST - SR_ST;
  localparam int ZS_DLY = H_ST - SCL_ST;

  assign busy = 1'b0;

  logic [LAST:1] vld;

  always_ff @(posedge clk) begin
    if (rst) vld <= '0;
    else vld <= {vld[LAST-1:1], start & ~busy};
  end

  // stage 1: input register, narrowed to the used coordinate width
  logic signed [CW_USED-1:0] e_in, n_in, u_in;
  logic signed [31:0]        e1, n1, u1;

  assign e_in = east_pos[CW_USED-1:0];
  assign n_in = north_pos[CW_USED-1:0];
  assign u_in = up_pos[CW_USED-1:0];

  always_ff @(posedge clk) begin
    e1 <= 32'(e_in);
    n1 <= 32'(n_in);
    u1 <= 32'(u_in);
  end

  // stage 2: squares
  logic [63:0]        e_sq, n_sq, u_sq2;
  logic signed [31:0] u2;

  always_ff @(posedge clk) begin
    e_sq  <= 64'(e1 * e1);
    n_sq  <= 64'(n1 * n1);
    u_sq2 <= 64'(u1 * u1);
    u2    <= u1;
  end

  // stage 3: horizontal sum of squares
  logic [63:0]        s3, u_sq3;
  logic signed [31:0] u3;

  always_ff @(posedge clk) begin
    s3    <= e_sq + n_sq;
    u_sq3 <= u_sq2;
    u3    <= u2;
  end

  // stage 4: full sum and the pair shift that fills the root's word
  logic [63:0]        s4, tot4;
  logic [4:0]         t4;
  logic signed [31:0] u4;
  logic [5:0]         lz3;

  assign lz3 = 6'd63 - msb_index(s3);

  always_ff @(posedge clk) begin
    s4   <= s3;
    tot4 <= s3 + u_sq3;
    u4   <= u3;
    if (s3 == '0) t4 <= '0;
    else t4 <= (lz3[5:1] > 5'd31) ? 5'd31 : lz3[5:1];
  end

  // stage 5: scaled horizontal sum and matching up coordinate
  logic [63:0] s5;
  word_t       zs5;
  logic [63:0] u_abs, u_shl;

  assign u_abs = u4[31] ? 64'(-64'(u4)) : 64'(u4);
  assign u_shl = u_abs << t4;

  always_ff @(posedge clk) begin
    s5  <= s4 << {t4, 1'b0};
    zs5 <= u4[31] ? -word_t'(u_shl) : word_t'(u_shl);
  end

  // two square roots side by side, one result bit per stage
  logic [63:0] el_n [SQRT_STEPS];
  logic [63:0] el_r [SQRT_STEPS];
  logic [63:0] sr_n [SQRT_STEPS];
  logic [63:0] sr_r [SQRT_STEPS];

  for (genvar j = 0; j < SQRT_STEPS; j++) begin : g_sqrt
    localparam logic [63:0] BIT_J = 64'd1 << (62 - 2 * j);
    logic [63:0] eni, eri, sni, sri, etr, str;
    if (j == 0) begin : g_first
      assign eni = s5;
      assign eri = '0;
      assign sni = tot4;
      assign sri = '0;
    end else begin : g_next
      assign eni = el_n[j-1];
      assign eri = el_r[j-1];
      assign sni = sr_n[j-1];
      assign sri = sr_r[j-1];
    end
    assign etr = eri + BIT_J;
    assign str = sri + BIT_J;
    always_ff @(posedge clk) begin
      if (eni >= etr) begin
        el_n[j] <= eni - etr;
        el_r[j] <= (eri >> 1) + BIT_J;
      end else begin
        el_n[j] <= eni;
        el_r[j] <= eri >> 1;
      end
      if (sni >= str) begin
        sr_n[j] <= sni - str;
        sr_r[j] <= (sri >> 1) + BIT_J;
      end else begin
        sr_n[j] <= sni;
        sr_r[j] <= sri >> 1;
      end
    end
  end

  // up coordinate waits for the horizontal root
  word_t zs_d [ZS_DLY];

  always_ff @(posedge clk) begin
    zs_d[0] <= zs5;
    for (int k = 1; k < ZS_DLY; k++) zs_d[k] <= zs_d[k-1];
  end

  // azimuth cordic straight from the input register
  logic az_vld, el_vld;
  ang_t az_z, el_z;

  c2la_atan2 u_az (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[1]),
    .y         (word_t'(n1)),
    .x         (word_t'(e1)),
    .out_valid (az_vld),
    .z         (az_z)
  );

  c2la_atan2 u_el (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (vld[H_ST]),
    .y         (zs_d[ZS_DLY-1]),
    .x         (word_t'(el_r[SQRT_STEPS-1])),
    .out_valid (el_vld),
    .z         (el_z)
  );

  // rounding: magnitude plus half, then shift and restore sign
  logic             az_neg, el_neg;
  logic [Z_W-1:0]   az_mh, el_mh;
  logic [AZ_W-1:0]  az_rnd;
  logic [EL_W-1:0]  el_rnd;
  logic [Z_W-1:0]   az_q, el_q;

  assign az_q = az_mh >> RND_SH;
  assign el_q = el_mh >> RND_SH;

  always_ff @(posedge clk) begin
    az_neg <= az_z[Z_W-1];
    el_neg <= el_z[Z_W-1];
    az_mh  <= (az_z[Z_W-1] ? Z_W'(-az_z) : Z_W'(az_z)) + RND_HALF;
    el_mh  <= (el_z[Z_W-1] ? Z_W'(-el_z) : Z_W'(el_z)) + RND_HALF;
    az_rnd <= az_neg ? AZ_W'(-az_q) : AZ_W'(az_q);
    el_rnd <= el_neg ? EL_W'(-el_q) : EL_W'(el_q);
  end

  // alignment of azimuth and slant range with the elevation result
  logic [AZ_W-1:0] az_d [AZ_DLY];
  logic [31:0]     sr_d [SR_DLY];

  always_ff @(posedge clk) begin
    az_d[0] <= az_rnd;
    for (int k = 1; k < AZ_DLY; k++) az_d[k] <= az_d[k-1];
    sr_d[0] <= sr_r[SQRT_STEPS-1][31:0];
    for (int k = 1; k < SR_DLY; k++) sr_d[k] <= sr_d[k-1];
  end

  assign done            = vld[LAST];
  assign azimuth_angle   = az_d[AZ_DLY-1];
  assign elevation_angle = el_rnd;
  assign slant_range     = sr_d[SR_DLY-1];

`ifndef ASSERT_OFF
  a_az_align: assert property (@(posedge clk) disable iff (rst) az_vld == vld[AZ_Z])
    else $error("azimuth cordic out of step with valid chain");
  a_el_align: assert property (@(posedge clk) disable iff (rst) el_vld == vld[EL_Z])
    else $error("elevation cordic out of step with valid chain");
  a_origin: assert property (@(posedge clk) disable iff (rst)
    (done && slant_range == '0) |-> (azimuth_angle == '0 && elevation_angle == '0))
    else $error("zero range with nonzero angle");
  a_src: assert property (@(posedge clk) disable iff (rst) done |-> $past(start, LAST))
    else $error("result without an accepted item");
`endif

endmodule
